// ===== hdl/tnes_pkg.sv =====
// tnes_pkg: shared types, codes and constants for the note event scheduler
// used by every module in hdl/ but tnes_divider; depends on nothing

package tnes_pkg;

    localparam int unsigned QueueDepthDefault = 16;
    localparam int unsigned MaxResults        = 16;
    localparam int unsigned TimeW             = 32;
    localparam logic [23:0] NoteLenReset      = 24'd100000;

    typedef enum logic [2:0] {
        ACT_NOTE_ON  = 3'd0,
        ACT_NOTE_OFF = 3'd1,
        ACT_STEP     = 3'd2,
        ACT_PATTERN  = 3'd3,
        ACT_POLL     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        RES_NOTE_ON  = 2'd0,
        RES_NOTE_OFF = 2'd1,
        RES_DROPPED  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_DELAY    = 2'd1,
        REG_NOTE_LEN = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_POP,
        ST_DIVIDE,
        ST_OUT
    } state_t;

    // one queue entry
    typedef struct packed {
        logic        is_off;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] due;
    } entry_t;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic   insert;
        logic   pop;
        entry_t new_entry;
    } cell_ctl_t;

endpackage

// ===== hdl/tnes_cell.sv =====
// tnes_cell: one slot of the sorted event queue
// holds an entry, shifts toward the head on pop or away on insert; uses tnes_pkg

module tnes_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  tnes_pkg::cell_ctl_t ctl,
    input  logic                left_valid,
    input  tnes_pkg::entry_t    left_entry,
    input  logic                right_valid,
    input  tnes_pkg::entry_t    right_entry,
    output logic                valid,
    output tnes_pkg::entry_t    entry
);

    logic             valid_reg, valid_next;
    tnes_pkg::entry_t entry_reg, entry_next;
    logic             mine_later, left_later;

    // strict compare keeps insertion order among equal due times
    assign mine_later = valid_reg && (entry_reg.due > ctl.new_entry.due);
    assign left_later = left_valid && (left_entry.due > ctl.new_entry.due);

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctl.pop) begin
            valid_next = right_valid;
            entry_next = right_entry;
        end else if (ctl.insert) begin
            if (left_later) begin
                valid_next = 1'b1;
                entry_next = left_entry;
            end else if ((mine_later || !valid_reg) && left_valid) begin
                // new entry lands right after the last entry that is not later
                valid_next = 1'b1;
                entry_next = ctl.new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== hdl/tnes_divider.sv =====
// tnes_divider: 64 by 33 bit restoring divider, one quotient bit a cycle
// used by the core for the running mean; depends on nothing

module tnes_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] div_reg, div_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [33:0] trial;

    assign trial = {rem_reg, quo_reg[63]};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
            cnt_next = 7'd64;
        end else if (cnt_reg != 7'd0) begin
            cnt_next = cnt_reg - 7'd1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = 33'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = (cnt_reg != 7'd0);
    // mean never exceeds the largest latency, so it fits in 32 bits
    assign quotient = quo_reg[31:0];

endmodule

// ===== hdl/timestamped_note_event_scheduler_core.sv =====
// timestamped_note_event_scheduler_core: top level of the note event scheduler
// uses tnes_pkg, tnes_cell and tnes_divider
//
// Items enter on the s_axis channel: note on, note off, step advance, pattern
// complete or poll. Note events, if enabled, go into a sorted row of queue cells
// (earliest due first, equal due times in arrival order) and give no result,
// unless the queue is full, when one dropped item comes out on m_axis.
// A poll emits up to 16 due entries in order, with latency, running mean and peak.
// tlast marks the final result item of an input.
// One item is worked on at a time, and no item is taken while a result waits.
// The output register holds a result until m_axis_tready; while stalled the
// block waits and keeps all state. Reset empties the queue, clears the
// statistics and loads the register defaults; it needs no clearing pass.
// Registers on the APB port, by paddr[3:2]: 0 enable, 1 processing delay, 2 note length.

module timestamped_note_event_scheduler_core #(
    parameter int unsigned QUEUE_DEPTH = tnes_pkg::QueueDepthDefault
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: action[2:0], midi_channel[6:3], note_number[13:7],
    // note_velocity[20:14], now_us[52:21], zero[55:53]
    input  logic [55:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_channel[3:0], out_note[10:4], out_velocity[17:11],
    // pop_latency[49:18], average_latency[81:50], peak_latency[113:82],
    // queued_count[118:114], zero[119]
    output logic [119:0] m_axis_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned BurstW = $clog2(tnes_pkg::MaxResults + 1);

    // configuration
    logic        enable_reg;
    logic [19:0] delay_reg;
    logic [23:0] note_len_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b1;
            delay_reg    <= '0;
            note_len_reg <= tnes_pkg::NoteLenReset;
        end else if (wr_en) begin
            case (reg_sel)
                tnes_pkg::REG_ENABLE:   enable_reg   <= pwdata[0];
                tnes_pkg::REG_DELAY:    delay_reg    <= pwdata[19:0];
                tnes_pkg::REG_NOTE_LEN: note_len_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            tnes_pkg::REG_ENABLE:   prdata = {31'd0, enable_reg};
            tnes_pkg::REG_DELAY:    prdata = {12'd0, delay_reg};
            tnes_pkg::REG_NOTE_LEN: prdata = {8'd0, note_len_reg};
            default:                prdata = '0;
        endcase
    end

    // input fields
    logic [2:0]  in_action;
    logic [3:0]  in_channel;
    logic [6:0]  in_note, in_vel;
    logic [31:0] in_now;
    assign in_action  = s_axis_tdata[2:0];
    assign in_channel = s_axis_tdata[6:3];
    assign in_note    = s_axis_tdata[13:7];
    assign in_vel     = s_axis_tdata[20:14];
    assign in_now     = s_axis_tdata[52:21];

    tnes_pkg::state_t state_reg, state_next;
    logic        in_fire, out_fire;
    logic [31:0] tick_reg, now_reg;
    logic [31:0] mean_reg, peak_reg, sent_reg, lat_reg;
    logic [CntW-1:0]   count_reg;
    logic [BurstW-1:0] burst_reg;
    tnes_pkg::entry_t  pend_reg;
    logic        pend_drop_reg;

    // output register
    logic         ov_reg;
    logic [119:0] od_reg;
    logic [1:0]   ou_reg;
    logic         ol_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // cell row
    tnes_pkg::cell_ctl_t ctl;
    logic             c_valid [QUEUE_DEPTH];
    tnes_pkg::entry_t c_entry [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic             lv, rv;
        tnes_pkg::entry_t le, re;
        if (i == 0) begin : g_first
            // head cell sees a valid neighbor that is never later
            assign lv = 1'b1;
            assign le = '0;
        end else begin : g_mid
            assign lv = c_valid[i-1];
            assign le = c_entry[i-1];
        end
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign re = '0;
        end else begin : g_inner
            assign rv = c_valid[i+1];
            assign re = c_entry[i+1];
        end
        tnes_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
            .left_valid(lv), .left_entry(le),
            .right_valid(rv), .right_entry(re),
            .valid(c_valid[i]), .entry(c_entry[i])
        );
    end

    // due time with saturation
    logic [33:0] due_sum;
    logic [31:0] due_sat;
    assign due_sum = {2'b0, tick_reg} + {14'd0, delay_reg}
                   + (pend_reg.is_off ? {10'd0, note_len_reg} : 34'd0);
    assign due_sat = (due_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : due_sum[31:0];

    logic pop_ok;
    assign pop_ok = (count_reg != '0) && (burst_reg != BurstW'(tnes_pkg::MaxResults))
                  && (c_entry[0].due <= now_reg) && !ov_reg;

    assign ctl.insert    = (state_reg == tnes_pkg::ST_INSERT) && !pend_drop_reg;
    assign ctl.pop       = (state_reg == tnes_pkg::ST_POP) && pop_ok;
    assign ctl.new_entry = '{is_off: pend_reg.is_off, channel: pend_reg.channel,
                             note: pend_reg.note, velocity: pend_reg.velocity,
                             due: due_sat};

    // divider for the mean
    logic        div_start, div_busy;
    logic [31:0] div_q;
    logic [63:0] mul_sum;
    logic [31:0] lat_now;
    assign lat_now   = now_reg - c_entry[0].due;
    assign mul_sum   = 64'(mean_reg) * 64'(sent_reg) + 64'(lat_now);
    assign div_start = ctl.pop;

    tnes_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(mul_sum), .divisor(33'(sent_reg) + 33'd1),
        .busy(div_busy), .quotient(div_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tnes_pkg::ST_IDLE: begin
                if (in_fire && in_action == tnes_pkg::ACT_POLL) begin
                    state_next = tnes_pkg::ST_POP;
                end else if (in_fire && enable_reg && (in_action == tnes_pkg::ACT_NOTE_ON
                             || in_action == tnes_pkg::ACT_NOTE_OFF)) begin
                    state_next = tnes_pkg::ST_INSERT;
                end
            end
            tnes_pkg::ST_INSERT: begin
                if (!pend_drop_reg) state_next = tnes_pkg::ST_IDLE;
                else if (!ov_reg) state_next = tnes_pkg::ST_IDLE;
            end
            tnes_pkg::ST_POP: begin
                if (pop_ok) state_next = tnes_pkg::ST_DIVIDE;
                else if (!ov_reg) state_next = tnes_pkg::ST_IDLE;
            end
            tnes_pkg::ST_DIVIDE: begin
                if (!div_busy) state_next = tnes_pkg::ST_OUT;
            end
            tnes_pkg::ST_OUT: begin
                state_next = tnes_pkg::ST_POP;
            end
            default: state_next = tnes_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    assign s_axis_tready = (state_reg == tnes_pkg::ST_IDLE) && !ov_reg;

    // result that goes out once the mean is known; last is decided by a look-ahead
    logic [31:0] new_peak;
    logic        more_due;
    assign new_peak = (lat_reg > peak_reg) ? lat_reg : peak_reg;
    assign more_due = (count_reg != '0) && (c_entry[0].due <= now_reg)
                    && (burst_reg != BurstW'(tnes_pkg::MaxResults));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tnes_pkg::ST_IDLE;
            count_reg <= '0;
            tick_reg  <= '0;
            mean_reg  <= '0;
            peak_reg  <= '0;
            sent_reg  <= '0;
            burst_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_fire) ov_reg <= 1'b0;
            case (state_reg)
                tnes_pkg::ST_IDLE: begin
                    if (in_fire) begin
                        now_reg   <= in_now;
                        burst_reg <= '0;
                        pend_reg.is_off   <= (in_action == tnes_pkg::ACT_NOTE_OFF);
                        pend_reg.channel  <= in_channel;
                        pend_reg.note     <= in_note;
                        pend_reg.velocity <= (in_action == tnes_pkg::ACT_NOTE_OFF) ?
                                             7'd0 : in_vel;
                        pend_reg.due      <= '0;
                        pend_drop_reg <= (count_reg >= CntW'(QUEUE_DEPTH));
                        if (enable_reg && in_action == tnes_pkg::ACT_STEP) begin
                            tick_reg <= in_now;
                        end
                    end
                end
                tnes_pkg::ST_INSERT: begin
                    if (!pend_drop_reg) begin
                        count_reg <= count_reg + CntW'(1);
                    end else if (!ov_reg) begin
                        ov_reg <= 1'b1;
                        ou_reg <= tnes_pkg::RES_DROPPED;
                        ol_reg <= 1'b1;
                        od_reg <= {1'b0, 5'(count_reg), peak_reg, mean_reg, 32'd0,
                                   pend_reg.velocity, pend_reg.note, pend_reg.channel};
                    end
                end
                tnes_pkg::ST_POP: begin
                    if (pop_ok) begin
                        count_reg <= count_reg - CntW'(1);
                        burst_reg <= burst_reg + BurstW'(1);
                        lat_reg   <= lat_now;
                        pend_reg  <= c_entry[0];
                    end else if (!ov_reg && burst_reg != '0) begin
                        ol_reg <= 1'b1;
                    end
                end
                tnes_pkg::ST_DIVIDE: begin
                    if (!div_busy) begin
                        mean_reg <= div_q;
                        peak_reg <= new_peak;
                        if (sent_reg != 32'hFFFF_FFFF) sent_reg <= sent_reg + 32'd1;
                    end
                end
                tnes_pkg::ST_OUT: begin
                    ov_reg <= 1'b1;
                    ou_reg <= pend_reg.is_off ? tnes_pkg::RES_NOTE_OFF
                                              : tnes_pkg::RES_NOTE_ON;
                    ol_reg <= !more_due;
                    od_reg <= {1'b0, 5'(count_reg), peak_reg, mean_reg, lat_reg,
                               pend_reg.is_off ? 7'd0 : pend_reg.velocity,
                               pend_reg.note, pend_reg.channel};
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

endmodule

// ===== hdl/tnes_checker.sv =====
// tnes_checker: port-level assertions for the scheduler top level
// bound to timestamped_note_event_scheduler_core; uses tnes_pkg

module tnes_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // a result waiting keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // the block takes no item while a result waits
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && m_axis_tvalid |-> !s_axis_tready)
        else $error("item accepted while result pending");

    // a dropped item is always the only result
    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == tnes_pkg::RES_DROPPED |-> m_axis_tlast)
        else $error("dropped result not last");

    // peak never below the latency reported with it
    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[113:82] >= m_axis_tdata[49:18])
        else $error("peak below latency");

endmodule

bind timestamped_note_event_scheduler_core tnes_checker u_tnes_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for timestamped_note_event_scheduler_core
// depends on tnes_pkg and the core; carries its own scheduler predictor
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        tnes_pkg::result_kind_t kind;
        logic [3:0]   channel;
        logic [6:0]   note;
        logic [6:0]   velocity;
        logic [31:0]  latency;
        logic [31:0]  mean;
        logic [31:0]  peak;
        logic [4:0]   count;
        logic         last;
    } note_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    timestamped_note_event_scheduler_core i_dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // predictor state
    tnes_pkg::entry_t sched_q[$];
    logic [31:0]  tick_us, mean_us, peak_us, sent_n;
    logic         sched_en;
    logic [19:0]  delay_us;
    logic [23:0]  len_us;
    note_result_t expected_results[$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    localparam int WatchdogLimit = 20000;

    task automatic predict_item(logic [2:0] act, logic [3:0] ch, logic [6:0] nt,
                                logic [6:0] vel, logic [31:0] now);
        logic [32:0]      due;
        logic [63:0]      sum;
        logic [31:0]      lat;
        tnes_pkg::entry_t e;
        note_result_t     r;
        int               pos, k;
        if (act == tnes_pkg::ACT_POLL) begin
            k = 0;
            while (k < tnes_pkg::MaxResults && sched_q.size() > 0
                   && sched_q[0].due <= now) begin
                e = sched_q.pop_front();
                lat = now - e.due;
                sum = 64'(mean_us) * 64'(sent_n) + 64'(lat);
                mean_us = 32'(sum / (64'(sent_n) + 64'd1));
                if (lat > peak_us) peak_us = lat;
                if (sent_n != 32'hFFFF_FFFF) sent_n++;
                r.kind = e.is_off ? tnes_pkg::RES_NOTE_OFF : tnes_pkg::RES_NOTE_ON;
                r.channel = e.channel;
                r.note = e.note;
                r.velocity = e.is_off ? 7'd0 : e.velocity;
                r.latency = lat;
                r.mean = mean_us;
                r.peak = peak_us;
                r.count = 5'(sched_q.size());
                r.last = 1'b0;
                expected_results.push_back(r);
                k++;
            end
            if (k > 0) expected_results[$].last = 1'b1;
        end else if (sched_en && (act == tnes_pkg::ACT_NOTE_ON
                                  || act == tnes_pkg::ACT_NOTE_OFF)) begin
            due = 33'(tick_us) + 33'(delay_us);
            if (act == tnes_pkg::ACT_NOTE_OFF) due += 33'(len_us);
            if (due[32]) due = 33'h0_FFFF_FFFF;
            e.is_off = (act == tnes_pkg::ACT_NOTE_OFF);
            e.channel = ch;
            e.note = nt;
            e.velocity = e.is_off ? 7'd0 : vel;
            e.due = due[31:0];
            if (sched_q.size() >= tnes_pkg::QueueDepthDefault) begin
                r.kind = tnes_pkg::RES_DROPPED;
                r.channel = ch;
                r.note = nt;
                r.velocity = e.velocity;
                r.latency = '0;
                r.mean = mean_us;
                r.peak = peak_us;
                r.count = 5'(sched_q.size());
                r.last = 1'b1;
                expected_results.push_back(r);
            end else begin
                pos = sched_q.size();
                while (pos > 0 && sched_q[pos-1].due > e.due) pos--;
                sched_q.insert(pos, e);
            end
        end else if (sched_en && act == tnes_pkg::ACT_STEP) begin
            tick_us = now;
        end
    endtask

    // sends one item; predicts it when accepted; tvalid stays up so the next
    // item can follow at once
    task automatic send_item(logic [2:0] act, logic [3:0] ch, logic [6:0] nt,
                             logic [6:0] vel, logic [31:0] now);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, now, vel, nt, ch, act};
        do @(posedge aclk); while (!s_axis_tready);
        predict_item(act, ch, nt, vel, now);
        n_items++;
    endtask

    task automatic stop_sending;
        s_axis_tvalid <= 1'b0;
    endtask

    // sends one item, then in one case of four a random gap
    task automatic send_paced(logic [2:0] act, logic [3:0] ch, logic [6:0] nt,
                              logic [6:0] vel, logic [31:0] now);
        send_item(act, ch, nt, vel, now);
        if ($urandom_range(0, 3) == 0) begin
            stop_sending();
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained;
        stop_sending();
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(tnes_pkg::reg_index_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tnes_pkg::REG_ENABLE: sched_en = val[0];
            tnes_pkg::REG_DELAY: delay_us = val[19:0];
            default: len_us = val[23:0];
        endcase
    endtask

    // result checker
    always @(posedge aclk) begin
        note_result_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {tnes_pkg::result_kind_t'(m_axis_tuser), m_axis_tdata[3:0],
                       m_axis_tdata[10:4], m_axis_tdata[17:11], m_axis_tdata[49:18],
                       m_axis_tdata[81:50], m_axis_tdata[113:82], m_axis_tdata[118:114],
                       m_axis_tlast};
                n_results++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $realtime, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %h, actual %h", $realtime, want, got);
                        $display("   kind %0d/%0d ch %0d/%0d note %0d/%0d vel %0d/%0d",
                                 want.kind, got.kind, want.channel, got.channel,
                                 want.note, got.note, want.velocity, got.velocity);
                        $display("   lat %0d/%0d mean %0d/%0d peak %0d/%0d cnt %0d/%0d last %0d/%0d",
                                 want.latency, got.latency, want.mean, got.mean,
                                 want.peak, got.peak, want.count, got.count,
                                 want.last, got.last);
                        errors++;
                    end
                end
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // watchdog on progress
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no progress for %0d cycles", WatchdogLimit);
            $display("** timestamped_note_event_scheduler_core: FAILED **");
            $finish;
        end
    end

    task automatic test_extremes;
        stall_mode = 0;
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'd0);
        send_item(tnes_pkg::ACT_STEP, 4'd0, 7'd0, 7'd0, 32'd1000);
        send_item(tnes_pkg::ACT_NOTE_ON, 4'd15, 7'd127, 7'd127, 32'd0);
        send_item(tnes_pkg::ACT_NOTE_OFF, 4'd0, 7'd0, 7'd127, 32'd0);
        send_item(tnes_pkg::ACT_NOTE_ON, 4'd5, 7'd60, 7'd1, 32'd0);
        send_item(tnes_pkg::ACT_PATTERN, 4'd3, 7'd3, 7'd3, 32'd5);
        send_item(3'd7, 4'd9, 7'd9, 7'd9, 32'd5);
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'd999);
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'd1500);
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_overflow_and_full;
        write_reg(tnes_pkg::REG_DELAY, 32'd1000000);
        write_reg(tnes_pkg::REG_NOTE_LEN, 32'd10000000);
        send_item(tnes_pkg::ACT_STEP, 4'd0, 7'd0, 7'd0, 32'hFFFF_FF00);
        for (int i = 0; i < 18; i++)
            send_item(i[0] ? tnes_pkg::ACT_NOTE_OFF : tnes_pkg::ACT_NOTE_ON,
                      4'(i), 7'(i), 7'(100 + i), 32'd0);
        stall_mode = 2;
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(tnes_pkg::REG_ENABLE, 32'd0);
        send_item(tnes_pkg::ACT_NOTE_ON, 4'd1, 7'd1, 7'd1, 32'd0);
        send_item(tnes_pkg::ACT_STEP, 4'd0, 7'd0, 7'd0, 32'd77);
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'hFFFF_FFFF);
        wait_drained();
        write_reg(tnes_pkg::REG_ENABLE, 32'd1);
        write_reg(tnes_pkg::REG_DELAY, 32'd0);
        write_reg(tnes_pkg::REG_NOTE_LEN, 32'd0);
    endtask

    // phrases: step, a few notes, then polls around the due times
    task automatic test_random_phrases(int n_new);
        logic [31:0] base;
        int          n;
        int          stop_at;
        base = 32'd0;
        stop_at = n_items + n_new;
        while (n_items < stop_at) begin
            stall_mode = $urandom_range(0, 2);
            base = ($urandom_range(0, 9) == 0) ? $urandom() : base + $urandom_range(0, 50000);
            send_paced(tnes_pkg::ACT_STEP, 4'($urandom()), 7'($urandom()), 7'($urandom()),
                       base);
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_paced(3'($urandom_range(0, 1)), 4'($urandom()), 7'($urandom()),
                           7'($urandom()), $urandom());
            if ($urandom_range(0, 4) == 0)
                send_paced(3'($urandom_range(3, 7)), 4'($urandom()), 7'($urandom()),
                           7'($urandom()), $urandom());
            send_paced(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, base + $urandom_range(0, 4000));
            if ($urandom_range(0, 1) == 0)
                send_paced(tnes_pkg::ACT_POLL, 4'($urandom()), 7'($urandom()),
                           7'($urandom()),
                           base + delay_us + len_us + $urandom_range(0, 3000));
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        send_item(tnes_pkg::ACT_POLL, 4'd0, 7'd0, 7'd0, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    initial begin
        sched_en = 1'b1;
        delay_us = '0;
        len_us = tnes_pkg::NoteLenReset;
        tick_us = '0;
        mean_us = '0;
        peak_us = '0;
        sent_n = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_overflow_and_full();
        write_reg(tnes_pkg::REG_DELAY, 32'd500);
        write_reg(tnes_pkg::REG_NOTE_LEN, 32'd2000);
        test_random_phrases(62);
        write_reg(tnes_pkg::REG_DELAY, 32'd0);
        write_reg(tnes_pkg::REG_NOTE_LEN, 32'd100000);
        test_random_phrases(62);
        $display("covered %0d input items and %0d results: full queue, time saturation,",
                 n_items, n_results);
        $display("disabled scheduling, ignored actions and burst polls under output stalls");
        if (errors == 0) begin
            $display("** timestamped_note_event_scheduler_core: PASSED **");
        end else begin
            $display("** timestamped_note_event_scheduler_core: FAILED **");
        end
        $finish;
    end
endmodule
